[hdl/bbl_pkg.sv]
// Shared types and constants for the Butterworth low-pass biquad.
package bbl_pkg;

   localparam int SampleWidth = 16;
   localparam int CoefWidth   = 18;
   localparam int HistWidth   = 24;
   localparam int CountWidth  = 7;
   localparam int IndexWidth  = 3;

   typedef enum logic [IndexWidth-1:0] {
      REG_COEF_B0 = 3'd0,
      REG_COEF_B1 = 3'd1,
      REG_COEF_B2 = 3'd2,
      REG_COEF_A1 = 3'd3,
      REG_COEF_A2 = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic signed [CoefWidth-1:0] b0;
      logic signed [CoefWidth-1:0] b1;
      logic signed [CoefWidth-1:0] b2;
      logic signed [CoefWidth-1:0] a1;
      logic signed [CoefWidth-1:0] a2;
   } coef_type;

   typedef struct packed {
      logic signed [HistWidth-1:0]   y_hist;
      logic signed [SampleWidth-1:0] sample;
   } mac_result_type;

   localparam logic signed [CoefWidth-1:0] CoefB0Reset = 18'sd41874;
   localparam logic signed [CoefWidth-1:0] CoefB1Reset = 18'sd83748;
   localparam logic signed [CoefWidth-1:0] CoefB2Reset = 18'sd41874;
   localparam logic signed [CoefWidth-1:0] CoefA1Reset = 18'sd74906;
   localparam logic signed [CoefWidth-1:0] CoefA2Reset = 18'sd27053;

endpackage

[hdl/bbl_mac.sv]
// Biquad multiply-accumulate with rounding, saturation and warm-up bypass.
module bbl_mac
   import bbl_pkg::*;
(
   input  logic signed [SampleWidth-1:0] x0,
   input  logic signed [SampleWidth-1:0] x1,
   input  logic signed [SampleWidth-1:0] x2,
   input  logic signed [HistWidth-1:0]   y1,
   input  logic signed [HistWidth-1:0]   y2,
   input  coef_type                      coef,
   input  logic                          filter_on,
   output mac_result_type                result
);

   localparam int ProdFfWidth = CoefWidth + SampleWidth;
   localparam int ProdFbWidth = CoefWidth + HistWidth;
   localparam int AccWidth    = 47;
   localparam int YWideWidth  = AccWidth - 16;

   localparam logic signed [YWideWidth-1:0] HistMax = YWideWidth'(8388607);
   localparam logic signed [YWideWidth-1:0] HistMin = -YWideWidth'(8388608);
   localparam logic signed [16:0] OutMax = 17'sd32767;
   localparam logic signed [16:0] OutMin = -17'sd32768;

   logic signed [ProdFfWidth-1:0] p_b0, p_b1, p_b2;
   logic signed [ProdFbWidth-1:0] p_a1, p_a2;
   logic signed [AccWidth-1:0]    ff_sum, acc, acc_rnd;
   logic signed [YWideWidth-1:0]  y_wide;
   logic signed [HistWidth-1:0]   y_sat;
   logic signed [HistWidth:0]     y_rnd;
   logic signed [16:0]            s_wide;
   logic signed [SampleWidth-1:0] s_sat;

   assign p_b0 = $signed(coef.b0) * x0;
   assign p_b1 = $signed(coef.b1) * x1;
   assign p_b2 = $signed(coef.b2) * x2;
   assign p_a1 = $signed(coef.a1) * y1;
   assign p_a2 = $signed(coef.a2) * y2;

   assign ff_sum  = AccWidth'(p_b0) + AccWidth'(p_b1) + AccWidth'(p_b2);
   assign acc     = (ff_sum <<< 8) - AccWidth'(p_a1) - AccWidth'(p_a2);
   assign acc_rnd = acc + AccWidth'(32768);
   assign y_wide  = acc_rnd[AccWidth-1:16];

   always_comb begin
      if (y_wide > HistMax) begin
         y_sat = HistMax[HistWidth-1:0];
      end else if (y_wide < HistMin) begin
         y_sat = HistMin[HistWidth-1:0];
      end else begin
         y_sat = y_wide[HistWidth-1:0];
      end
   end

   assign y_rnd  = (HistWidth+1)'(y_sat) + (HistWidth+1)'(128);
   assign s_wide = y_rnd[HistWidth:8];

   always_comb begin
      if (s_wide > OutMax) begin
         s_sat = OutMax[SampleWidth-1:0];
      end else if (s_wide < OutMin) begin
         s_sat = OutMin[SampleWidth-1:0];
      end else begin
         s_sat = s_wide[SampleWidth-1:0];
      end
   end

   always_comb begin
      if (filter_on) begin
         result.y_hist = y_sat;
         result.sample = s_sat;
      end else begin
         result.y_hist = {x0, 8'b0};
         result.sample = x0;
      end
   end

endmodule

[hdl/butterworth_biquad_lowpass_top.sv]
// Top level of the second-order Butterworth low-pass biquad with stream ports.
// The result of an accepted input word is registered in the output register on the clock edge that accepts it.
// Throughput: one word per cycle while the output is not stalled; the feedback multiply-accumulate is combinational.
// A new word is taken while the output register is empty or being drained in the same cycle.
// Reset clears the histories, the warm-up counter and the output valid, and reloads the
// default coefficients.
module butterworth_biquad_lowpass_top
   import bbl_pkg::*;
#(
   parameter int WARMUP = 100
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [15:0]           req_tdata,   // [15:0] sample_in
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [15:0]           rsp_tdata,   // [15:0] sample_out
   output logic [0:0]            rsp_tuser,   // [0] settled
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [IndexWidth-1:0] csr_index,
   input  logic [CoefWidth-1:0]  csr_data
);

   localparam logic [CountWidth-1:0] WarmupLimit = CountWidth'(WARMUP);

   coef_type                      coef_ff, coef_in;
   logic signed [SampleWidth-1:0] x1_ff, x2_ff;
   logic signed [HistWidth-1:0]   y1_ff, y2_ff;
   logic [CountWidth-1:0]         count_ff, count_in;
   logic                          valid_ff, valid_in;
   logic [SampleWidth-1:0]        out_ff;
   logic                          settled_ff;
   logic                          accept, filter_on;
   mac_result_type                mac_out;

   assign csr_ready  = 1'b1;
   assign req_tready = !valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign filter_on  = count_ff >= WarmupLimit;

   bbl_mac u_mac (
      .x0        ($signed(req_tdata)),
      .x1        (x1_ff),
      .x2        (x2_ff),
      .y1        (y1_ff),
      .y2        (y2_ff),
      .coef      (coef_ff),
      .filter_on (filter_on),
      .result    (mac_out)
   );

   always_comb begin
      coef_in = coef_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_COEF_B0: coef_in.b0 = csr_data;
            REG_COEF_B1: coef_in.b1 = csr_data;
            REG_COEF_B2: coef_in.b2 = csr_data;
            REG_COEF_A1: coef_in.a1 = csr_data;
            REG_COEF_A2: coef_in.a2 = csr_data;
            default:     coef_in = coef_ff;
         endcase
      end
   end

   always_comb begin
      count_in = count_ff;
      if (accept && !filter_on) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff  <= '{b0: CoefB0Reset, b1: CoefB1Reset, b2: CoefB2Reset,
                       a1: CoefA1Reset, a2: CoefA2Reset};
         x1_ff    <= '0;
         x2_ff    <= '0;
         y1_ff    <= '0;
         y2_ff    <= '0;
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         coef_ff  <= coef_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
         if (accept) begin
            x1_ff <= $signed(req_tdata);
            x2_ff <= x1_ff;
            y1_ff <= mac_out.y_hist;
            y2_ff <= y1_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         out_ff     <= mac_out.sample;
         settled_ff <= filter_on;
      end
   end

   assign rsp_tvalid   = valid_ff;
   assign rsp_tdata    = out_ff;
   assign rsp_tuser[0] = settled_ff;

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= WarmupLimit)
      else $error("Warm-up counter ran past its limit.");

   a_bypass_word: assert property (@(posedge clock) disable iff (reset)
      (accept && !filter_on) |=> (rsp_tdata == $past(req_tdata) && rsp_tuser[0] == 1'b0))
      else $error("Warm-up word was not passed through unchanged.");

   a_settled_sticky: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> filter_on)
      else $error("Settled word seen while the filter is still warming up.");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("Input stalled although the output register is empty.");

endmodule
